### src/sot_pkg.sv
// package for the service offer table: sizes, codes and types
`default_nettype none
package sot_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] TIME_SLACK_MS = 32'd999;
    localparam logic [23:0] TTL_BAD       = 24'hFFFFFF;
    localparam logic [15:0] SVC_BAD       = 16'hFFFF;
    localparam logic [7:0]  VER_BAD       = 8'hFF;
    localparam logic [15:0] INST_ANY      = 16'hFFFF;

    localparam logic [2:0] OP_OFFER = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_BOOT  = 3'd3;
    localparam logic [2:0] OP_FIND  = 3'd4;
    localparam logic [2:0] OP_FADDR = 3'd5;

    localparam logic [3:0] EV_DONE     = 4'd0;
    localparam logic [3:0] EV_ADDED    = 4'd1;
    localparam logic [3:0] EV_CHANGED  = 4'd2;
    localparam logic [3:0] EV_RELIABLE = 4'd3;
    localparam logic [3:0] EV_REMOVED  = 4'd4;
    localparam logic [3:0] EV_FOUND    = 4'd5;
    localparam logic [3:0] EV_NOTFOUND = 4'd6;
    localparam logic [3:0] EV_INVALID  = 4'd7;
    localparam logic [3:0] EV_FULL     = 4'd8;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    // slot record: 16+8+16+32+16+8+24+8+32
    typedef struct packed {
        logic [15:0] service;
        logic [7:0]  version;
        logic [15:0] inst_num;
        logic [31:0] address;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [23:0] ttl;
        logic [7:0]  count;
        logic [31:0] last_ms;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_EMIT,
        ST_STATUS
    } t_state;

endpackage
`default_nettype wire

### src/sot_ram.sv
// generic single-port ram with registered read
`default_nettype none
module sot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_addr,
    input  wire [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### src/service_offer_table_top.sv
// top level of the service offer table: slot sweep over one ram
//
//  channel   direction  handshake        payload
//  input     in         i_valid/o_stall  opcode and key/endpoint/time fields
//  result    out        o_valid/i_stall  event code, entry fields, last
//  config    in         i_cfg_valid/o_cfg_ready  register index and data
//
// a valid input sweeps all TABLE_DEPTH slots, each through read, decide and write back,
// and emit, then goes to the status state, which for a new entry first sends the
// added event and then the status item; an invalid input skips the sweep.
// reset is synchronous and active low; it clears state, config and valid bits.
// while a result waits under stall the sweep holds and no input is taken.
`default_nettype none
module service_offer_table_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_opcode,
    input  wire  [15:0] i_service_id,
    input  wire  [7:0]  i_major_version,
    input  wire  [15:0] i_instance_id,
    input  wire  [31:0] i_ip_addr,
    input  wire  [15:0] i_port_num,
    input  wire  [7:0]  i_proto,
    input  wire  [23:0] i_ttl,
    input  wire  [23:0] i_elapsed,
    input  wire  [31:0] i_now_ms,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [3:0]  o_event_res,
    output logic [15:0] o_out_service_id,
    output logic [7:0]  o_out_major_version,
    output logic [15:0] o_out_instance_id,
    output logic [31:0] o_out_ip_addr,
    output logic [15:0] o_out_port,
    output logic [7:0]  o_out_proto,
    output logic [23:0] o_out_ttl,
    output logic        o_last,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    localparam int SW = sot_pkg::SLOT_W;

    // configuration registers
    logic [31:0] r_period;
    logic [7:0]  r_thresh;

    // captured input item
    logic [2:0]  r_op;
    logic [15:0] r_sv;
    logic [7:0]  r_ver;
    logic [15:0] r_inst;
    logic [31:0] r_ip;
    logic [15:0] r_port;
    logic [7:0]  r_proto;
    logic [23:0] r_ttl;
    logic [23:0] r_elapsed;
    logic [31:0] r_now;

    sot_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_idx;
    logic [sot_pkg::TABLE_DEPTH-1:0] r_vld;
    logic            r_hit;       // key match seen (offer/stop) or any find match
    logic            r_done;      // offer/stop/find-by-address already settled
    logic            r_free_ok;
    logic [SW-1:0]   r_free;
    logic [sot_pkg::CNT_W-1:0] r_nev;
    logic [3:0]      r_status;

    // pending event from the modify cycle
    logic            r_ev;
    logic [3:0]      r_ev_code;
    sot_pkg::t_slot  r_ev_slot;

    // output register
    logic        r_ovalid;
    logic [3:0]  r_ores;
    sot_pkg::t_slot r_oslot;
    logic        r_olast;

    // ram
    logic           ram_we;
    logic [SW-1:0]  ram_addr;
    sot_pkg::t_slot ram_wdata, ram_rdata;

    sot_ram #(.WIDTH(sot_pkg::SLOT_BITS), .DEPTH(1 << SW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic accept, out_free, is_last_idx;
    assign out_free    = !r_ovalid || !i_stall;
    assign o_stall     = (r_state != sot_pkg::ST_IDLE);
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign is_last_idx = (r_idx == SW'(sot_pkg::TABLE_DEPTH - 1));

    // per slot decision, combinational on the read data
    logic           cur_v, key_eq, ep_eq, find_m, faddr_m;
    logic           m_we, m_clr, m_ev;
    logic [3:0]     m_code;
    sot_pkg::t_slot m_slot, m_evslot;
    logic [32:0]    lim, diff;

    always_comb begin
        cur_v   = r_vld[r_idx];
        key_eq  = cur_v && ram_rdata.service == r_sv && ram_rdata.version == r_ver
                  && ram_rdata.inst_num == r_inst;
        ep_eq   = ram_rdata.address == r_ip && ram_rdata.port == r_port
                  && ram_rdata.proto == r_proto;
        find_m  = cur_v && ram_rdata.service == r_sv && ram_rdata.version == r_ver
                  && (r_inst == sot_pkg::INST_ANY || ram_rdata.inst_num == r_inst);
        faddr_m = cur_v && ram_rdata.service == r_sv && ram_rdata.version == r_ver
                  && ram_rdata.address == r_ip;
        lim     = {1'b0, r_period} + {1'b0, sot_pkg::TIME_SLACK_MS};
        diff    = {1'b0, r_now - ram_rdata.last_ms};
        m_we    = 1'b0;
        m_clr   = 1'b0;
        m_ev    = 1'b0;
        m_code  = sot_pkg::EV_DONE;
        m_slot  = ram_rdata;
        m_evslot = ram_rdata;
        case (r_op)
            sot_pkg::OP_OFFER: begin
                if (key_eq && !r_done) begin
                    m_we        = 1'b1;
                    m_slot.ttl  = r_ttl;
                    if (!ep_eq) begin
                        m_slot.address = r_ip;
                        m_slot.port    = r_port;
                        m_slot.proto   = r_proto;
                        m_slot.last_ms = r_now;
                        m_slot.count   = 8'd1;
                        m_ev           = 1'b1;
                        m_code         = sot_pkg::EV_CHANGED;
                    end else if (r_period != '0 && r_thresh != '0) begin
                        m_slot.last_ms = r_now;
                        if (ram_rdata.count < r_thresh) begin
                            if (diff <= lim) begin
                                m_slot.count = ram_rdata.count + 8'd1;
                                if (m_slot.count == r_thresh) begin
                                    m_ev   = 1'b1;
                                    m_code = sot_pkg::EV_RELIABLE;
                                end
                            end else begin
                                m_slot.count = 8'd1;
                            end
                        end
                    end
                    m_evslot = m_slot;
                end
            end
            sot_pkg::OP_STOP: begin
                if (key_eq && !r_done) begin
                    m_clr            = 1'b1;
                    m_ev             = 1'b1;
                    m_code           = sot_pkg::EV_REMOVED;
                    m_evslot.service = r_sv;
                    m_evslot.version = r_ver;
                    m_evslot.inst_num = r_inst;
                    m_evslot.address = r_ip;
                    m_evslot.port    = r_port;
                    m_evslot.proto   = r_proto;
                    m_evslot.ttl     = '0;
                end
            end
            sot_pkg::OP_TICK: begin
                if (cur_v) begin
                    if (ram_rdata.ttl >= r_elapsed) begin
                        m_we       = 1'b1;
                        m_slot.ttl = ram_rdata.ttl - r_elapsed;
                    end else begin
                        m_clr        = 1'b1;
                        m_ev         = 1'b1;
                        m_code       = sot_pkg::EV_REMOVED;
                        m_evslot.ttl = '0;
                    end
                end
            end
            sot_pkg::OP_BOOT: begin
                if (cur_v && ram_rdata.address == r_ip) begin
                    m_clr        = 1'b1;
                    m_ev         = 1'b1;
                    m_code       = sot_pkg::EV_REMOVED;
                    m_evslot.ttl = '0;
                end
            end
            sot_pkg::OP_FIND: begin
                if (find_m) begin
                    m_ev   = 1'b1;
                    m_code = sot_pkg::EV_FOUND;
                end
            end
            sot_pkg::OP_FADDR: begin
                if (faddr_m && !r_done) begin
                    m_ev   = 1'b1;
                    m_code = sot_pkg::EV_FOUND;
                end
            end
            default: ;
        endcase
    end

    // input validity
    logic key_ok, in_bad;
    always_comb begin
        key_ok = i_service_id != sot_pkg::SVC_BAD && i_major_version != sot_pkg::VER_BAD;
        case (i_opcode) inside
            sot_pkg::OP_OFFER: in_bad = !key_ok || i_instance_id == sot_pkg::INST_ANY
                                        || i_ttl == '0 || i_ttl == sot_pkg::TTL_BAD;
            sot_pkg::OP_STOP:  in_bad = !key_ok || i_instance_id == sot_pkg::INST_ANY;
            sot_pkg::OP_TICK,
            sot_pkg::OP_BOOT:  in_bad = 1'b0;
            sot_pkg::OP_FIND:  in_bad = !key_ok;
            sot_pkg::OP_FADDR: in_bad = !key_ok || i_ip_addr == '0 || i_port_num == '0;
            default:           in_bad = 1'b1;
        endcase
    end

    // status cycle: code to send and whether a new entry goes in first
    logic       st_add;
    logic [3:0] st_res;
    always_comb begin
        st_add = r_op == sot_pkg::OP_OFFER && r_status == sot_pkg::EV_DONE
                 && !r_hit && r_free_ok;
        st_res = r_status;
        if (r_status == sot_pkg::EV_DONE) begin
            case (r_op) inside
                sot_pkg::OP_OFFER: begin
                    if (!r_hit) st_res = r_free_ok ? sot_pkg::EV_ADDED : sot_pkg::EV_FULL;
                end
                sot_pkg::OP_STOP, sot_pkg::OP_FIND, sot_pkg::OP_FADDR: begin
                    if (!r_hit) st_res = sot_pkg::EV_NOTFOUND;
                end
                default: ;
            endcase
        end
    end

    // output register loads an event or a status transfer
    logic out_load;
    always_comb begin
        out_load = (r_state == sot_pkg::ST_EMIT && r_ev && out_free
                    && r_nev < sot_pkg::CNT_W'(sot_pkg::TABLE_DEPTH))
                   || (r_state == sot_pkg::ST_STATUS && out_free);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sot_pkg::ST_IDLE:   if (accept) n_state = in_bad ? sot_pkg::ST_STATUS
                                                             : sot_pkg::ST_READ;
            sot_pkg::ST_READ:   n_state = sot_pkg::ST_SCAN;
            sot_pkg::ST_SCAN:   n_state = sot_pkg::ST_EMIT;
            sot_pkg::ST_EMIT: begin
                if (!r_ev || out_free)
                    n_state = is_last_idx ? sot_pkg::ST_STATUS : sot_pkg::ST_READ;
            end
            sot_pkg::ST_STATUS: begin
                if (out_free) n_state = st_add ? sot_pkg::ST_STATUS : sot_pkg::ST_IDLE;
            end
            default:            n_state = sot_pkg::ST_IDLE;
        endcase
    end

    // ram port control
    always_comb begin
        ram_addr  = r_idx;
        ram_we    = 1'b0;
        ram_wdata = m_slot;
        unique case (r_state)
            sot_pkg::ST_SCAN: ram_we = m_we;
            sot_pkg::ST_STATUS: begin
                // new entry written into the lowest free slot
                ram_addr  = r_free;
                ram_wdata = '{service: r_sv, version: r_ver, inst_num: r_inst,
                              address: r_ip, port: r_port, proto: r_proto, ttl: r_ttl,
                              count: 8'd1, last_ms: r_now};
                ram_we    = out_free && st_add;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sot_pkg::ST_IDLE;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
            r_period <= '0;
            r_thresh <= '0;
            r_ev     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    sot_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                    sot_pkg::CFG_THRESH: r_thresh <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                sot_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_op <= i_opcode; r_sv <= i_service_id; r_ver <= i_major_version;
                        r_inst <= i_instance_id; r_ip <= i_ip_addr;
                        r_port <= i_port_num; r_proto <= i_proto; r_ttl <= i_ttl;
                        r_elapsed <= i_elapsed; r_now <= i_now_ms;
                        r_idx <= '0; r_hit <= 1'b0; r_done <= 1'b0;
                        r_free_ok <= 1'b0; r_nev <= '0;
                        r_status <= in_bad ? sot_pkg::EV_INVALID : sot_pkg::EV_DONE;
                    end
                end
                sot_pkg::ST_READ: ;
                sot_pkg::ST_SCAN: begin
                    r_ev      <= m_ev;
                    r_ev_code <= m_code;
                    r_ev_slot <= m_evslot;
                    if (m_clr) r_vld[r_idx] <= 1'b0;
                    if (!cur_v && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_idx;
                    end
                    if ((r_op == sot_pkg::OP_OFFER || r_op == sot_pkg::OP_STOP) && key_eq)
                        r_done <= 1'b1;
                    if (r_op == sot_pkg::OP_FADDR && faddr_m) r_done <= 1'b1;
                    if ((r_op == sot_pkg::OP_OFFER || r_op == sot_pkg::OP_STOP) && key_eq)
                        r_hit <= 1'b1;
                    if ((r_op == sot_pkg::OP_FIND && find_m)
                        || (r_op == sot_pkg::OP_FADDR && faddr_m))
                        r_hit <= 1'b1;
                end
                sot_pkg::ST_EMIT: begin
                    if (!r_ev || out_free) begin
                        // events past the cap are dropped
                        if (r_ev && r_nev < sot_pkg::CNT_W'(sot_pkg::TABLE_DEPTH)) begin
                            r_ores   <= r_ev_code;
                            r_oslot  <= r_ev_slot;
                            r_olast  <= 1'b0;
                            r_nev    <= r_nev + 1'b1;
                        end
                        r_ev  <= 1'b0;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                sot_pkg::ST_STATUS: begin
                    if (out_free) begin
                        // added event first, status follows on the next pass
                        r_ores  <= st_res;
                        r_olast <= !st_add;
                        r_oslot <= st_add ? ram_wdata : '0;
                        if (st_add) begin
                            r_vld[r_free] <= 1'b1;
                            r_hit         <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // status state is left only after the status item; an added event loops back
    // through status because r_hit then makes the next pass a plain done

    assign o_valid             = r_ovalid;
    assign o_event_res         = r_ores;
    assign o_out_service_id    = r_oslot.service;
    assign o_out_major_version = r_oslot.version;
    assign o_out_instance_id   = r_oslot.inst_num;
    assign o_out_ip_addr       = r_oslot.address;
    assign o_out_port          = r_oslot.port;
    assign o_out_proto         = r_oslot.proto;
    assign o_out_ttl           = r_oslot.ttl;
    assign o_last              = r_olast;

`ifndef ASSERT_OFF
    // no input is taken while a sweep is running
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sot_pkg::ST_IDLE) |-> !accept)
        else $error("input accepted while busy");
    // the sweep index is zero when a sweep begins
    a_idx_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sot_pkg::ST_READ && $past(r_state) == sot_pkg::ST_IDLE)
        |-> r_idx == '0)
        else $error("sweep did not start at slot zero");
    // a status item returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == sot_pkg::ST_STATUS && r_ovalid && r_olast
         && $past(out_free)) |-> r_state == sot_pkg::ST_IDLE)
        else $error("status item without return to idle");
`endif
endmodule
`default_nettype wire

### verif/tb_top.sv
// testbench for the service offer table: directed and random stimulus, scoreboard check
`timescale 1ns / 1ps
module tb_top;

    // one result item as seen on the output ports
    typedef struct packed {
        logic [3:0]  res;
        logic [15:0] svc;
        logic [7:0]  ver;
        logic [15:0] inst;
        logic [31:0] ip;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [23:0] ttl;
        logic        last;
    } t_result;

    // one input item
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] svc;
        logic [7:0]  ver;
        logic [15:0] inst;
        logic [31:0] ip;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [23:0] ttl;
        logic [23:0] elapsed;
        logic [31:0] now;
    } t_request;

    // shadow of the offer table plus the expected event stream
    class offer_scoreboard;
        bit             valid [sot_pkg::TABLE_DEPTH];
        sot_pkg::t_slot slot  [sot_pkg::TABLE_DEPTH];
        logic [31:0]    period;
        logic [7:0]     thresh;
        t_result        pending[$];
        t_result        burst[$];
        int             mismatches;
        int             checked;
        int             hist[16];

        function void clear();
            foreach (valid[i]) valid[i] = 1'b0;
            period = '0;
            thresh = '0;
            pending.delete();
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == sot_pkg::CFG_PERIOD) period = data;
            else thresh = data[7:0];
        endfunction

        function void push(logic [3:0] res, logic [15:0] svc, logic [7:0] ver,
                           logic [15:0] inst, logic [31:0] ip, logic [15:0] port,
                           logic [7:0] proto, logic [23:0] ttl, logic last);
            t_result r;
            // events past the cap are dropped, the status always goes out
            if (!last && burst.size() >= 16) return;
            r = '{res, svc, ver, inst, ip, port, proto, ttl, last};
            burst.push_back(r);
        endfunction

        function void push_slot(logic [3:0] res, int s, bit zero_ttl);
            push(res, slot[s].service, slot[s].version, slot[s].inst_num,
                 slot[s].address, slot[s].port, slot[s].proto,
                 zero_ttl ? 24'd0 : slot[s].ttl, 1'b0);
        endfunction

        function int lookup(logic [15:0] svc, logic [7:0] ver, logic [15:0] inst);
            for (int i = 0; i < sot_pkg::TABLE_DEPTH; i++)
                if (valid[i] && slot[i].service == svc && slot[i].version == ver &&
                    slot[i].inst_num == inst)
                    return i;
            return -1;
        endfunction

        // predicts the results of one accepted input and updates the shadow
        function void note_request(t_request q);
            int s;
            int i;
            bit key_ok;
            bit any;
            logic [32:0] diff;
            logic [32:0] lim;
            logic [3:0] stat;
            burst.delete();
            key_ok = (q.svc != sot_pkg::SVC_BAD) && (q.ver != sot_pkg::VER_BAD);
            stat = sot_pkg::EV_DONE;
            case (q.op)
                sot_pkg::OP_OFFER: begin
                    if (q.ttl == '0 || q.ttl == sot_pkg::TTL_BAD || !key_ok ||
                        q.inst == sot_pkg::INST_ANY) begin
                        stat = sot_pkg::EV_INVALID;
                    end else begin
                        s = lookup(q.svc, q.ver, q.inst);
                        if (s >= 0) begin
                            slot[s].ttl = q.ttl;
                            if (slot[s].address != q.ip || slot[s].port != q.port ||
                                slot[s].proto != q.proto) begin
                                slot[s].address = q.ip;
                                slot[s].port = q.port;
                                slot[s].proto = q.proto;
                                slot[s].last_ms = q.now;
                                slot[s].count = 8'd1;
                                push_slot(sot_pkg::EV_CHANGED, s, 1'b0);
                            end else if (period != '0 && thresh != '0) begin
                                diff = {1'b0, q.now - slot[s].last_ms};
                                lim = {1'b0, period} + {1'b0, sot_pkg::TIME_SLACK_MS};
                                if (slot[s].count < thresh) begin
                                    if (diff <= lim) begin
                                        slot[s].count = slot[s].count + 8'd1;
                                        if (slot[s].count == thresh)
                                            push_slot(sot_pkg::EV_RELIABLE, s, 1'b0);
                                    end else begin
                                        slot[s].count = 8'd1;
                                    end
                                end
                                slot[s].last_ms = q.now;
                            end
                        end else begin
                            for (i = 0; i < sot_pkg::TABLE_DEPTH; i++)
                                if (!valid[i]) break;
                            if (i >= sot_pkg::TABLE_DEPTH) begin
                                stat = sot_pkg::EV_FULL;
                            end else begin
                                valid[i] = 1'b1;
                                slot[i] = '{q.svc, q.ver, q.inst, q.ip, q.port, q.proto,
                                            q.ttl, 8'd1, q.now};
                                push_slot(sot_pkg::EV_ADDED, i, 1'b0);
                            end
                        end
                    end
                end
                sot_pkg::OP_STOP: begin
                    if (!key_ok || q.inst == sot_pkg::INST_ANY) begin
                        stat = sot_pkg::EV_INVALID;
                    end else begin
                        s = lookup(q.svc, q.ver, q.inst);
                        if (s < 0) begin
                            stat = sot_pkg::EV_NOTFOUND;
                        end else begin
                            valid[s] = 1'b0;
                            push(sot_pkg::EV_REMOVED, q.svc, q.ver, q.inst, q.ip, q.port,
                                 q.proto, 24'd0, 1'b0);
                        end
                    end
                end
                sot_pkg::OP_TICK: begin
                    for (i = 0; i < sot_pkg::TABLE_DEPTH; i++) begin
                        if (valid[i]) begin
                            if (slot[i].ttl >= q.elapsed) begin
                                slot[i].ttl = slot[i].ttl - q.elapsed;
                            end else begin
                                valid[i] = 1'b0;
                                push_slot(sot_pkg::EV_REMOVED, i, 1'b1);
                            end
                        end
                    end
                end
                sot_pkg::OP_BOOT: begin
                    for (i = 0; i < sot_pkg::TABLE_DEPTH; i++) begin
                        if (valid[i] && slot[i].address == q.ip) begin
                            valid[i] = 1'b0;
                            push_slot(sot_pkg::EV_REMOVED, i, 1'b1);
                        end
                    end
                end
                sot_pkg::OP_FIND: begin
                    any = 1'b0;
                    if (!key_ok) begin
                        stat = sot_pkg::EV_INVALID;
                    end else begin
                        for (i = 0; i < sot_pkg::TABLE_DEPTH; i++) begin
                            if (valid[i] && slot[i].service == q.svc &&
                                slot[i].version == q.ver &&
                                (q.inst == sot_pkg::INST_ANY ||
                                 slot[i].inst_num == q.inst)) begin
                                any = 1'b1;
                                push_slot(sot_pkg::EV_FOUND, i, 1'b0);
                            end
                        end
                        if (!any) stat = sot_pkg::EV_NOTFOUND;
                    end
                end
                sot_pkg::OP_FADDR: begin
                    if (!key_ok || q.ip == '0 || q.port == '0) begin
                        stat = sot_pkg::EV_INVALID;
                    end else begin
                        for (i = 0; i < sot_pkg::TABLE_DEPTH; i++)
                            if (valid[i] && slot[i].service == q.svc &&
                                slot[i].version == q.ver && slot[i].address == q.ip)
                                break;
                        if (i >= sot_pkg::TABLE_DEPTH) stat = sot_pkg::EV_NOTFOUND;
                        else push_slot(sot_pkg::EV_FOUND, i, 1'b0);
                    end
                end
                default: stat = sot_pkg::EV_INVALID;
            endcase
            push(stat, 16'd0, 8'd0, 16'd0, 32'd0, 16'd0, 8'd0, 24'd0, 1'b1);
            foreach (burst[k]) pending.push_back(burst[k]);
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result res=%0d last=%0b", got.res, got.last);
                return;
            end
            want = pending.pop_front();
            hist[want.res]++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected res=%0d svc=%h ver=%h inst=%h ip=%h",
                             want.res, want.svc, want.ver, want.inst, want.ip);
                    $display("  port=%h proto=%h ttl=%h last=%b", want.port, want.proto,
                             want.ttl, want.last);
                    $display("  got res=%0d svc=%h ver=%h inst=%h ip=%h",
                             got.res, got.svc, got.ver, got.inst, got.ip);
                    $display("  port=%h proto=%h ttl=%h last=%b", got.port, got.proto,
                             got.ttl, got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_request    req;
    logic        out_valid;
    logic        out_stall;
    t_result     res_port;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    offer_scoreboard sb;
    int  send_idle_pct;   // percent of cycles the sender sits out
    int  recv_idle_pct;   // percent of cycles the receiver stalls
    bit  hold_off;        // long receiver hold-off request
    int  cycle_count;
    int  requests_sent;

    service_offer_table_top DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (in_valid),
        .o_stall             (in_stall),
        .i_opcode            (req.op),
        .i_service_id        (req.svc),
        .i_major_version     (req.ver),
        .i_instance_id       (req.inst),
        .i_ip_addr           (req.ip),
        .i_port_num          (req.port),
        .i_proto             (req.proto),
        .i_ttl               (req.ttl),
        .i_elapsed           (req.elapsed),
        .i_now_ms            (req.now),
        .o_valid             (out_valid),
        .i_stall             (out_stall),
        .o_event_res         (res_port.res),
        .o_out_service_id    (res_port.svc),
        .o_out_major_version (res_port.ver),
        .o_out_instance_id   (res_port.inst),
        .o_out_ip_addr       (res_port.ip),
        .o_out_port          (res_port.port),
        .o_out_proto         (res_port.proto),
        .o_out_ttl           (res_port.ttl),
        .o_last              (res_port.last),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    // free-running clock, 20 ns period
    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // watchdog: the slowest run is far below this
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // receiver: random stall at the falling edge, or a long hold-off when asked
    initial begin
        out_stall = 1;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: a result transfer happens at a rising edge with valid and no stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(res_port);
    end

    // present one input item and hold it until the block takes it
    task automatic send_request(t_request q);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        req <= q;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(q);
        requests_sent++;
        @(negedge clk);
    endtask

    // register write, only called with nothing in flight
    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    // wait until every expected result arrived, then let the sweep settle
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (3 * sot_pkg::TABLE_DEPTH + 10) @(negedge clk);
    endtask

    function automatic t_request mk(logic [2:0] op, logic [15:0] svc, logic [7:0] ver,
                                    logic [15:0] inst, logic [31:0] ip,
                                    logic [15:0] port, logic [7:0] proto,
                                    logic [23:0] ttl, logic [23:0] el, logic [31:0] now);
        mk = '{op, svc, ver, inst, ip, port, proto, ttl, el, now};
    endfunction

    // random item biased toward a small key space so entries collide and reach reliable
    logic [31:0] clock_ms;
    function automatic t_request rand_request();
        t_request q;
        logic [191:0] raw;
        int pick;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        q = raw[178:0];
        pick = $urandom_range(99);
        if (pick < 85) begin
            q.svc = 16'($urandom_range(3));
            q.ver = 8'($urandom_range(1));
            q.inst = 16'($urandom_range(5));
            q.ip = 32'h0A000000 | $urandom_range(3);
            q.port = 16'(30000 + $urandom_range(1));
            q.proto = 8'($urandom_range(1));
            q.ttl = 24'($urandom_range(1, 50));
            q.elapsed = 24'($urandom_range(15));
            clock_ms = clock_ms + $urandom_range(1500);
            q.now = clock_ms;
            if (pick < 40) q.op = sot_pkg::OP_OFFER;
            else if (pick < 50) q.op = sot_pkg::OP_STOP;
            else if (pick < 58) q.op = sot_pkg::OP_TICK;
            else if (pick < 62) q.op = sot_pkg::OP_BOOT;
            else if (pick < 75) q.op = sot_pkg::OP_FIND;
            else q.op = sot_pkg::OP_FADDR;
            if ($urandom_range(9) == 0) q.inst = sot_pkg::INST_ANY;
        end
        // otherwise fully random noise, including opcodes 6 and 7
        rand_request = q;
    endfunction

    initial begin
        t_request q;
        sb = new();
        sb.clear();
        rst_n = 0;
        in_valid = 0;
        req = '0;
        cfg_valid = 0;
        cfg_index = sot_pkg::CFG_PERIOD;
        cfg_data = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        requests_sent = 0;
        clock_ms = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reliability counting on, threshold two
        write_reg(sot_pkg::CFG_PERIOD, 32'd1000);
        write_reg(sot_pkg::CFG_THRESH, 32'd2);

        // directed: every operation, invalid fields, full table, reliable, cap
        send_request(mk(sot_pkg::OP_OFFER, 16'h0001, 8'h01, 16'h0001, 32'hC0A80001, 16'd1,
                        8'd6, 24'd100, 24'd0, 32'd1000));
        send_request(mk(sot_pkg::OP_OFFER, 16'h0001, 8'h01, 16'h0001, 32'hC0A80001, 16'd1,
                        8'd6, 24'd100, 24'd0, 32'd2500));
        send_request(mk(sot_pkg::OP_OFFER, 16'h0001, 8'h01, 16'h0001, 32'hC0A80001, 16'd1,
                        8'd6, 24'd100, 24'd0, 32'd9000));
        send_request(mk(sot_pkg::OP_OFFER, 16'h0001, 8'h01, 16'h0001, 32'hC0A80002, 16'd2,
                        8'd17, 24'd100, 24'd0, 32'd9100));
        send_request(mk(sot_pkg::OP_OFFER, 16'h0002, 8'h00, 16'h0000, 32'h0, 16'hFFFF,
                        8'hFF, 24'd0, 24'd0, 32'd0));
        send_request(mk(sot_pkg::OP_OFFER, 16'h0002, 8'h00, 16'h0000, 32'h0, 16'hFFFF,
                        8'hFF, sot_pkg::TTL_BAD, 24'd0, 32'd0));
        send_request(mk(sot_pkg::OP_OFFER, sot_pkg::SVC_BAD, 8'h00, 16'h0000, 32'h1, 16'd1,
                        8'd0, 24'd5, 24'd0, 32'd0));
        send_request(mk(sot_pkg::OP_OFFER, 16'h0002, sot_pkg::VER_BAD, 16'h0000, 32'h1,
                        16'd1, 8'd0, 24'd5, 24'd0, 32'd0));
        send_request(mk(sot_pkg::OP_OFFER, 16'h0002, 8'h00, sot_pkg::INST_ANY, 32'h1, 16'd1,
                        8'd0, 24'd5, 24'd0, 32'd0));
        // fill the table, then one more for the full status
        for (int i = 0; i < sot_pkg::TABLE_DEPTH; i++)
            send_request(mk(sot_pkg::OP_OFFER, 16'hFFFE, 8'hFE, 16'(i),
                            (i < 8) ? 32'hFFFFFFFF : 32'h0, 16'd7, 8'd17,
                            24'(24'hFFFFFE - i), 24'd0, 32'hFFFFFFFF));
        send_request(mk(sot_pkg::OP_FIND, 16'hFFFE, 8'hFE, sot_pkg::INST_ANY, 0, 0, 0, 0,
                        0, 0));
        send_request(mk(sot_pkg::OP_FADDR, 16'hFFFE, 8'hFE, 0, 32'hFFFFFFFF, 16'd7, 0, 0,
                        0, 0));
        send_request(mk(sot_pkg::OP_FADDR, 16'hFFFE, 8'hFE, 0, 32'h0, 16'd7, 0, 0, 0, 0));
        send_request(mk(sot_pkg::OP_STOP, 16'hFFFE, 8'hFE, 16'd3, 32'h12345678, 16'd9,
                        8'd1, 0, 0, 0));
        send_request(mk(sot_pkg::OP_STOP, 16'hFFFE, 8'hFE, 16'd3, 0, 0, 0, 0, 0, 0));
        send_request(mk(sot_pkg::OP_BOOT, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0));
        send_request(mk(sot_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0));
        send_request(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        // random phases with different register settings and idling mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(sot_pkg::CFG_PERIOD, 32'd500);
                    write_reg(sot_pkg::CFG_THRESH, 32'd3);
                    send_idle_pct = 33; recv_idle_pct = 67;
                end
                1: begin
                    write_reg(sot_pkg::CFG_PERIOD, 32'hFFFFFFFF);
                    write_reg(sot_pkg::CFG_THRESH, 32'd255);
                    send_idle_pct = 67; recv_idle_pct = 33;
                end
                2: begin
                    write_reg(sot_pkg::CFG_PERIOD, 32'd0);
                    write_reg(sot_pkg::CFG_THRESH, 32'd1);
                    send_idle_pct = 0; recv_idle_pct = 0;
                    hold_off = 1;
                end
                default: begin
                    write_reg(sot_pkg::CFG_PERIOD, 32'd200);
                    write_reg(sot_pkg::CFG_THRESH, 32'd0);
                end
            endcase
            for (int n = 0; n < 17; n++) begin
                q = rand_request();
                send_request(q);
            end
            drain();
        end

        $display("covered %0d inputs, %0d results: added %0d, changed %0d, reliable %0d,",
                 requests_sent, sb.checked, sb.hist[sot_pkg::EV_ADDED],
                 sb.hist[sot_pkg::EV_CHANGED], sb.hist[sot_pkg::EV_RELIABLE]);
        $display("removed %0d, found %0d, not found %0d, invalid %0d, full %0d",
                 sb.hist[sot_pkg::EV_REMOVED], sb.hist[sot_pkg::EV_FOUND],
                 sb.hist[sot_pkg::EV_NOTFOUND], sb.hist[sot_pkg::EV_INVALID],
                 sb.hist[sot_pkg::EV_FULL]);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
